/* rtl/core/rcbp_pkg.sv */
package rcbp_pkg;

    localparam int MAX_SLOTS = 64;
    localparam int SLOT_W    = 6;
    localparam int TOP_W     = 7;
    localparam int CNT_W     = 16;
    localparam int STRIDE_W  = 17;
    localparam int PROD_W    = STRIDE_W + SLOT_W;

    localparam logic [CNT_W-1:0] CNT_LIMIT = {CNT_W{1'b1}};

    typedef enum logic [2:0] {
        OP_ALLOC  = 3'd0,
        OP_REF    = 3'd1,
        OP_UNREF  = 3'd2,
        OP_INIT   = 3'd3,
        OP_DEINIT = 3'd4
    } t_op;

    typedef enum logic [2:0] {
        STS_OK    = 3'd0,
        STS_PARAM = 3'd1,
        STS_STATE = 3'd2,
        STS_EMPTY = 3'd3,
        STS_FREE  = 3'd4,
        STS_LIMIT = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        CFG_BASE  = 2'd0,
        CFG_SIZE  = 2'd1,
        CFG_ALIGN = 2'd2,
        CFG_SLOTS = 2'd3
    } t_cfg_reg;

    typedef enum logic [1:0] {
        S_IDLE  = 2'd0,
        S_EXEC  = 2'd1,
        S_SWEEP = 2'd2
    } t_state;

    typedef struct packed {
        logic [2:0]        operation;
        logic [SLOT_W-1:0] slot_index;
    } t_in;

    typedef struct packed {
        t_status           status;
        logic [SLOT_W-1:0] granted_slot;
        logic [31:0]       block_address;
        logic [15:0]       block_bytes;
        logic [CNT_W-1:0]  new_count;
        logic [TOP_W-1:0]  free_count;
    } t_out;

    typedef struct packed {
        logic accept;
        logic exec;
        logic sweep;
    } t_cmd;

    typedef struct packed {
        logic out_free;
        logic init_go;
        logic sweep_last;
    } t_stat;

endpackage

/* rtl/core/rcbp_ctrl.sv */
module rcbp_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  rcbp_pkg::t_stat i_stat,
    output rcbp_pkg::t_cmd  o_cmd,
    output logic            o_in_stall
);

    rcbp_pkg::t_state r_state;
    rcbp_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rcbp_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            rcbp_pkg::S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = rcbp_pkg::S_EXEC;
                end
            end
            rcbp_pkg::S_EXEC: begin
                if (i_stat.out_free) begin
                    o_cmd.exec = 1'b1;
                    n_state    = i_stat.init_go ? rcbp_pkg::S_SWEEP : rcbp_pkg::S_IDLE;
                end
            end
            rcbp_pkg::S_SWEEP: begin
                o_cmd.sweep = 1'b1;
                if (i_stat.sweep_last) begin
                    n_state = rcbp_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = rcbp_pkg::S_IDLE;
            end
        endcase
    end

endmodule

/* rtl/core/rcbp_dp.sv */
module rcbp_dp (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic [1:0]      i_cfg_index,
    input  logic [31:0]     i_cfg_data,
    input  rcbp_pkg::t_in   i_in_data,
    input  logic            i_out_stall,
    input  rcbp_pkg::t_cmd  i_cmd,
    output rcbp_pkg::t_stat o_stat,
    output logic            o_out_valid,
    output rcbp_pkg::t_out  o_out_data
);

    localparam int SW = rcbp_pkg::SLOT_W;
    localparam int TW = rcbp_pkg::TOP_W;
    localparam int CW = rcbp_pkg::CNT_W;

    logic [31:0]   r_cfg_base;
    logic [15:0]   r_cfg_size;
    logic [12:0]   r_cfg_align;
    logic [TW-1:0] r_cfg_slots;

    logic                          r_ready;
    logic [TW-1:0]                 r_pool_size;
    logic [TW-1:0]                 r_top;
    logic [31:0]                   r_held_base;
    logic [15:0]                   r_held_size;
    logic [rcbp_pkg::STRIDE_W-1:0] r_stride;

    logic [2:0]    r_op;
    logic [SW-1:0] r_idx;
    logic [CW-1:0] r_cnt_q;
    logic [SW-1:0] r_stk_q;
    logic [SW-1:0] r_sweep;

    logic            r_out_valid;
    rcbp_pkg::t_out  r_out;

    logic [CW-1:0] mem_cnt [rcbp_pkg::MAX_SLOTS];
    logic [SW-1:0] mem_stk [rcbp_pkg::MAX_SLOTS];

    rcbp_pkg::t_out                w_res;
    logic                          w_init_go;
    logic                          n_ready;
    logic [TW-1:0]                 n_top;
    logic                          w_cnt_we;
    logic [SW-1:0]                 w_cnt_wa;
    logic [CW-1:0]                 w_cnt_wd;
    logic                          w_stk_we;
    logic [SW-1:0]                 w_stk_wa;
    logic [SW-1:0]                 w_stk_wd;
    logic [TW-1:0]                 w_top_dec;
    logic [TW-1:0]                 w_sweep_pos;
    logic [12:0]                   w_align;
    logic [rcbp_pkg::STRIDE_W-1:0] w_amask;
    logic [rcbp_pkg::STRIDE_W-1:0] w_stride;
    logic [rcbp_pkg::PROD_W-1:0]   w_prod;
    logic                          w_idx_bad;
    logic [CW-1:0]                 w_cnt_inc;
    logic [CW-1:0]                 w_cnt_dec;

    assign w_top_dec   = r_top - TW'(1);
    assign w_sweep_pos = r_pool_size - TW'(1) - TW'(r_sweep);
    assign w_align     = (r_cfg_align == 13'd0) ? 13'd1 : r_cfg_align;
    assign w_amask     = rcbp_pkg::STRIDE_W'(w_align) - rcbp_pkg::STRIDE_W'(1);
    assign w_stride    = (rcbp_pkg::STRIDE_W'(r_cfg_size) + w_amask) & ~w_amask;
    assign w_prod      = rcbp_pkg::PROD_W'(r_stride) * rcbp_pkg::PROD_W'(r_stk_q);
    assign w_idx_bad   = (TW'(r_idx) >= r_pool_size);
    assign w_cnt_inc   = r_cnt_q + CW'(1);
    assign w_cnt_dec   = r_cnt_q - CW'(1);

    always_comb begin
        w_res            = '0;
        w_res.status     = rcbp_pkg::STS_OK;
        w_init_go        = 1'b0;
        n_ready          = r_ready;
        n_top            = r_top;
        w_cnt_we         = 1'b0;
        w_cnt_wa         = r_idx;
        w_cnt_wd         = '0;
        w_stk_we         = 1'b0;
        w_stk_wa         = r_top[SW-1:0];
        w_stk_wd         = r_idx;
        case (rcbp_pkg::t_op'(r_op))
            rcbp_pkg::OP_ALLOC: begin
                if (!r_ready) begin
                    w_res.status = rcbp_pkg::STS_STATE;
                end else if (r_top == '0) begin
                    w_res.status = rcbp_pkg::STS_EMPTY;
                end else begin
                    n_top               = w_top_dec;
                    w_cnt_we            = 1'b1;
                    w_cnt_wa            = r_stk_q;
                    w_cnt_wd            = CW'(1);
                    w_res.granted_slot  = r_stk_q;
                    w_res.block_address = r_held_base + 32'(w_prod);
                    w_res.block_bytes   = r_held_size;
                    w_res.new_count     = CW'(1);
                end
            end
            rcbp_pkg::OP_REF: begin
                if (!r_ready) begin
                    w_res.status = rcbp_pkg::STS_STATE;
                end else if (w_idx_bad) begin
                    w_res.status = rcbp_pkg::STS_PARAM;
                end else if (r_cnt_q == rcbp_pkg::CNT_LIMIT) begin
                    w_res.status    = rcbp_pkg::STS_LIMIT;
                    w_res.new_count = r_cnt_q;
                end else begin
                    w_cnt_we        = 1'b1;
                    w_cnt_wd        = w_cnt_inc;
                    w_res.new_count = w_cnt_inc;
                end
            end
            rcbp_pkg::OP_UNREF: begin
                if (!r_ready) begin
                    w_res.status = rcbp_pkg::STS_STATE;
                end else if (w_idx_bad) begin
                    w_res.status = rcbp_pkg::STS_PARAM;
                end else if (r_cnt_q == '0) begin
                    w_res.status = rcbp_pkg::STS_FREE;
                end else begin
                    w_cnt_we        = 1'b1;
                    w_cnt_wd        = w_cnt_dec;
                    w_res.new_count = w_cnt_dec;
                    if (w_cnt_dec == '0 && r_top < r_pool_size) begin
                        w_stk_we = 1'b1;
                        n_top    = r_top + TW'(1);
                    end
                end
            end
            rcbp_pkg::OP_INIT: begin
                if (r_cfg_size == '0 || r_cfg_slots == '0 ||
                    r_cfg_slots > TW'(rcbp_pkg::MAX_SLOTS)) begin
                    w_res.status = rcbp_pkg::STS_PARAM;
                end else if (r_ready) begin
                    w_res.status = rcbp_pkg::STS_STATE;
                end else begin
                    w_init_go = 1'b1;
                    n_ready   = 1'b1;
                    n_top     = r_cfg_slots;
                end
            end
            rcbp_pkg::OP_DEINIT: begin
                if (!r_ready) begin
                    w_res.status = rcbp_pkg::STS_STATE;
                end else begin
                    n_ready = 1'b0;
                    n_top   = '0;
                end
            end
            default: begin
                w_res.status = rcbp_pkg::STS_PARAM;
            end
        endcase
        w_res.free_count = n_top;

        if (i_cmd.sweep) begin
            w_cnt_we = 1'b1;
            w_cnt_wa = r_sweep;
            w_cnt_wd = '0;
            w_stk_we = 1'b1;
            w_stk_wa = w_sweep_pos[SW-1:0];
            w_stk_wd = r_sweep;
        end else if (!i_cmd.exec) begin
            w_cnt_we = 1'b0;
            w_stk_we = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_base  <= '0;
            r_cfg_size  <= 16'd64;
            r_cfg_align <= 13'd1;
            r_cfg_slots <= TW'(rcbp_pkg::MAX_SLOTS);
            r_ready     <= 1'b0;
            r_pool_size <= '0;
            r_top       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (rcbp_pkg::t_cfg_reg'(i_cfg_index))
                    rcbp_pkg::CFG_BASE:  r_cfg_base  <= i_cfg_data;
                    rcbp_pkg::CFG_SIZE:  r_cfg_size  <= i_cfg_data[15:0];
                    rcbp_pkg::CFG_ALIGN: r_cfg_align <= i_cfg_data[12:0];
                    rcbp_pkg::CFG_SLOTS: r_cfg_slots <= i_cfg_data[TW-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.exec) begin
                r_ready     <= n_ready;
                r_top       <= n_top;
                r_out_valid <= 1'b1;
                if (w_init_go) begin
                    r_pool_size <= r_cfg_slots;
                end
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op  <= i_in_data.operation;
            r_idx <= i_in_data.slot_index;
        end
        if (i_cmd.exec) begin
            r_out   <= w_res;
            r_sweep <= '0;
            if (w_init_go) begin
                r_held_base <= r_cfg_base;
                r_held_size <= r_cfg_size;
                r_stride    <= w_stride;
            end
        end else if (i_cmd.sweep) begin
            r_sweep <= r_sweep + SW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_cnt_we) begin
            mem_cnt[w_cnt_wa] <= w_cnt_wd;
        end
        if (i_cmd.accept) begin
            r_cnt_q <= mem_cnt[i_in_data.slot_index];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_stk_we) begin
            mem_stk[w_stk_wa] <= w_stk_wd;
        end
        if (i_cmd.accept) begin
            r_stk_q <= mem_stk[w_top_dec[SW-1:0]];
        end
    end

    assign o_stat.out_free   = !r_out_valid || !i_out_stall;
    assign o_stat.init_go    = w_init_go;
    assign o_stat.sweep_last = (TW'(r_sweep) == r_pool_size - TW'(1));
    assign o_out_valid       = r_out_valid;
    assign o_out_data        = r_out;

endmodule

/* rtl/core/refcounted_buffer_pool_top.sv */
// Reference-counted buffer pool: hands out fixed blocks from a LIFO free stack
// and keeps a 16-bit reference count per slot.
// Request channel: i_in_valid / o_in_stall, payload i_in_data (operation, slot).
// Result channel: o_out_valid / i_out_stall, payload o_out_data; exactly one
// result per request, in request order.
// Config: i_cfg_we writes i_cfg_data into register i_cfg_index (base, size,
// alignment, slot count); write only while the block is idle.
// On acceptance, the request's slot count and the stack top are read from the
// memories into registers; the execute state then does the read-modify-write
// and loads the output register once that register is free.
// A new request is not accepted until the previous one has completed.
// A successful init is followed by a sweep over all pool slots that clears the
// counts and refills the stack; requests are stalled during it.
// Reset: the pool is not initialized, free count zero, config registers at
// their defaults. Memories are not cleared by reset.
// A stalled result holds in the output register; one more request may be
// accepted, and it waits for the register before completing.
module refcounted_buffer_pool_top (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_we,
    input  logic [1:0]     i_cfg_index,
    input  logic [31:0]    i_cfg_data,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  rcbp_pkg::t_in  i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output rcbp_pkg::t_out o_out_data
);

    rcbp_pkg::t_cmd  w_cmd;
    rcbp_pkg::t_stat w_stat;

    rcbp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd),
        .o_in_stall (o_in_stall)
    );

    rcbp_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (i_in_data),
        .i_out_stall (i_out_stall),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("request accepted while previous one in flight");

    a_exec_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.exec |=> o_out_valid)
        else $error("completed request left no result");

    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({w_cmd.accept, w_cmd.exec, w_cmd.sweep}))
        else $error("controller issued overlapping commands");

    a_free_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.free_count <= 7'(rcbp_pkg::MAX_SLOTS)))
        else $error("free count above pool depth");

endmodule

/* tb/sv/refcounted_buffer_pool_top_tb.sv */
`timescale 1ns / 100ps

module refcounted_buffer_pool_top_tb;

    localparam int SIDE_SEND = 0;
    localparam int SIDE_RECV = 1;
    localparam int SETTLE_CYCLES = rcbp_pkg::MAX_SLOTS + 8;
    localparam logic [2:0] OP_BAD_LO = 3'd5;
    localparam logic [2:0] OP_BAD_HI = 3'd7;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_cfg_we = 1'b0;
    logic [1:0]       i_cfg_index = rcbp_pkg::CFG_BASE;
    logic [31:0]      i_cfg_data = '0;
    logic             i_in_valid = 1'b0;
    logic             o_in_stall;
    rcbp_pkg::t_in    i_in_data = '0;
    logic             o_out_valid;
    logic             i_out_stall = 1'b0;
    rcbp_pkg::t_out   o_out_data;

    refcounted_buffer_pool_top i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // register copies as written
    logic [31:0]                reg_base  = 32'd0;
    logic [15:0]                reg_size  = 16'd64;
    logic [12:0]                reg_align = 13'd1;
    logic [rcbp_pkg::TOP_W-1:0] reg_slots = 7'd64;

    // pool state as predicted
    bit                          pool_up = 1'b0;
    logic [rcbp_pkg::TOP_W-1:0]  pool_slots = '0;
    logic [rcbp_pkg::TOP_W-1:0]  free_depth = '0;
    logic [rcbp_pkg::SLOT_W-1:0] free_list [rcbp_pkg::MAX_SLOTS];
    logic [rcbp_pkg::CNT_W-1:0]  slot_refs [rcbp_pkg::MAX_SLOTS];
    logic [31:0]                 held_base = '0;
    logic [15:0]                 held_size = '0;
    logic [12:0]                 held_align = '0;

    rcbp_pkg::t_in  req_queue [$];
    rcbp_pkg::t_out due_results [$];
    int             mismatches = 0;
    int             send_gap_pct = 0;
    int             recv_stall_pct = 0;
    int             calm_left [2] = '{0, 0};

    function automatic rcbp_pkg::t_out pool_apply(rcbp_pkg::t_in rq);
        rcbp_pkg::t_out              r;
        logic [31:0]                 stride;
        logic [31:0]                 amask;
        logic [rcbp_pkg::SLOT_W-1:0] g;
        logic [rcbp_pkg::SLOT_W-1:0] ix;
        int                          i;
        r = '0;
        r.status = rcbp_pkg::STS_OK;
        ix = rq.slot_index;
        case (rq.operation)
            rcbp_pkg::OP_ALLOC: begin
                if (!pool_up) begin
                    r.status = rcbp_pkg::STS_STATE;
                end else if (free_depth == 0) begin
                    r.status = rcbp_pkg::STS_EMPTY;
                end else begin
                    free_depth = free_depth - 1'b1;
                    g = free_list[free_depth];
                    slot_refs[g] = 16'd1;
                    stride = {16'd0, held_size};
                    if (held_align > 13'd1) begin
                        amask = {19'd0, held_align} - 32'd1;
                        stride = (stride + amask) & ~amask;
                    end
                    r.granted_slot = g;
                    r.block_address = held_base + stride * {26'd0, g};
                    r.block_bytes = held_size;
                    r.new_count = 16'd1;
                end
            end
            rcbp_pkg::OP_REF: begin
                if (!pool_up) begin
                    r.status = rcbp_pkg::STS_STATE;
                end else if ({1'b0, ix} >= pool_slots) begin
                    r.status = rcbp_pkg::STS_PARAM;
                end else if (slot_refs[ix] == rcbp_pkg::CNT_LIMIT) begin
                    r.status = rcbp_pkg::STS_LIMIT;
                    r.new_count = slot_refs[ix];
                end else begin
                    slot_refs[ix] = slot_refs[ix] + 1'b1;
                    r.new_count = slot_refs[ix];
                end
            end
            rcbp_pkg::OP_UNREF: begin
                if (!pool_up) begin
                    r.status = rcbp_pkg::STS_STATE;
                end else if ({1'b0, ix} >= pool_slots) begin
                    r.status = rcbp_pkg::STS_PARAM;
                end else if (slot_refs[ix] == 0) begin
                    r.status = rcbp_pkg::STS_FREE;
                end else begin
                    slot_refs[ix] = slot_refs[ix] - 1'b1;
                    r.new_count = slot_refs[ix];
                    if (slot_refs[ix] == 0 && free_depth < pool_slots) begin
                        free_list[free_depth] = ix;
                        free_depth = free_depth + 1'b1;
                    end
                end
            end
            rcbp_pkg::OP_INIT: begin
                if (reg_size == 0 || reg_slots == 0 || reg_slots > rcbp_pkg::MAX_SLOTS) begin
                    r.status = rcbp_pkg::STS_PARAM;
                end else if (pool_up) begin
                    r.status = rcbp_pkg::STS_STATE;
                end else begin
                    held_base = reg_base;
                    held_size = reg_size;
                    held_align = (reg_align == 0) ? 13'd1 : reg_align;
                    pool_slots = reg_slots;
                    free_depth = reg_slots;
                    for (i = 0; i < reg_slots; i++) begin
                        slot_refs[i] = '0;
                        free_list[reg_slots - 1 - i] = 6'(i);
                    end
                    pool_up = 1'b1;
                end
            end
            rcbp_pkg::OP_DEINIT: begin
                if (!pool_up) begin
                    r.status = rcbp_pkg::STS_STATE;
                end else begin
                    pool_up = 1'b0;
                    free_depth = '0;
                end
            end
            default: r.status = rcbp_pkg::STS_PARAM;
        endcase
        r.free_count = free_depth;
        return r;
    endfunction

    function automatic bit skip_cycle(int side, int pct);
        if (calm_left[side] > 0) begin
            calm_left[side]--;
            return 1'b0;
        end
        if ($urandom_range(0, 99) < 3) begin
            calm_left[side] = $urandom_range(8, 40);
            return 1'b0;
        end
        return $urandom_range(0, 99) < pct;
    endfunction

    function automatic string fmt_result(rcbp_pkg::t_out r);
        return $sformatf("status=%0d slot=%0d addr=%h bytes=%0d count=%0d free=%0d",
                         r.status, r.granted_slot, r.block_address, r.block_bytes,
                         r.new_count, r.free_count);
    endfunction

    function automatic void flag_error(string msg);
        mismatches++;
        if (mismatches <= 10) begin
            $display("ERROR at %0t: %s", $time, msg);
        end
    endfunction

    function automatic void queue_req(logic [2:0] op, logic [rcbp_pkg::SLOT_W-1:0] ix);
        rcbp_pkg::t_in rq;
        rq.operation = op;
        rq.slot_index = ix;
        req_queue.push_back(rq);
    endfunction

    // request driver
    always @(posedge i_clk) begin : drv
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                due_results.push_back(pool_apply(i_in_data));
            end
            if (!i_in_valid || !o_in_stall) begin
                if (req_queue.size() != 0 && !skip_cycle(SIDE_SEND, send_gap_pct)) begin
                    i_in_valid <= 1'b1;
                    i_in_data <= req_queue.pop_front();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin : mon
        rcbp_pkg::t_out want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (due_results.size() == 0) begin
                    flag_error({"unexpected result ", fmt_result(o_out_data)});
                end else begin
                    want = due_results.pop_front();
                    if (o_out_data.status !== want.status ||
                        o_out_data.granted_slot !== want.granted_slot ||
                        o_out_data.block_address !== want.block_address ||
                        o_out_data.block_bytes !== want.block_bytes ||
                        o_out_data.new_count !== want.new_count ||
                        o_out_data.free_count !== want.free_count) begin
                        flag_error({"expected ", fmt_result(want),
                                    " got ", fmt_result(o_out_data)});
                    end
                end
            end
            i_out_stall <= skip_cycle(SIDE_RECV, recv_stall_pct);
        end
    end

    task automatic wait_quiet(bit settle);
        do @(posedge i_clk);
        while (req_queue.size() != 0 || i_in_valid || due_results.size() != 0);
        if (settle) begin
            repeat (SETTLE_CYCLES) @(posedge i_clk);
        end
    endtask

    task automatic write_reg(rcbp_pkg::t_cfg_reg r, logic [31:0] v);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= r;
        i_cfg_data <= v;
        case (r)
            rcbp_pkg::CFG_BASE:  reg_base = v;
            rcbp_pkg::CFG_SIZE:  reg_size = v[15:0];
            rcbp_pkg::CFG_ALIGN: reg_align = v[12:0];
            rcbp_pkg::CFG_SLOTS: reg_slots = v[rcbp_pkg::TOP_W-1:0];
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic load_setting(logic [31:0] b, logic [15:0] s, logic [12:0] a,
                                logic [rcbp_pkg::TOP_W-1:0] c);
        wait_quiet(1'b1);
        write_reg(rcbp_pkg::CFG_BASE, b);
        write_reg(rcbp_pkg::CFG_SIZE, {16'd0, s});
        write_reg(rcbp_pkg::CFG_ALIGN, {19'd0, a});
        write_reg(rcbp_pkg::CFG_SLOTS, {25'd0, c});
    endtask

    task automatic pick_setting(int n);
        logic [31:0]                b;
        logic [15:0]                s;
        logic [12:0]                a;
        logic [rcbp_pkg::TOP_W-1:0] c;
        case ($urandom_range(0, 3))
            0: b = 32'd0;
            1: b = 32'hFFFF_FFFF;
            default: b = $urandom;
        endcase
        case ($urandom_range(0, 3))
            0: s = 16'd1;
            1: s = 16'hFFFF;
            default: s = 16'($urandom_range(1, 16'hFFFF));
        endcase
        case (n % 4)
            0: a = 13'd0;
            1: a = 13'($urandom_range(1, 2047) * 2 + 1);
            2: a = 13'd1 << $urandom_range(0, 12);
            default: a = 13'd4096;
        endcase
        case (n % 3)
            0: c = 7'd64;
            1: c = 7'($urandom_range(1, 4));
            default: c = 7'($urandom_range(5, 20));
        endcase
        load_setting(b, s, a, c);
    endtask

    task automatic fill_sessions(int target);
        int                          made;
        int                          len;
        int                          j;
        int                          pick;
        logic [rcbp_pkg::SLOT_W-1:0] ix;
        made = 0;
        while (made < target) begin
            queue_req(rcbp_pkg::OP_INIT, 6'($urandom_range(0, 63)));
            len = $urandom_range(6, 40);
            for (j = 0; j < len; j++) begin
                pick = $urandom_range(0, 99);
                if ($urandom_range(0, 99) < 85) begin
                    ix = 6'($urandom_range(0, reg_slots - 1));
                end else begin
                    ix = 6'($urandom_range(0, 63));
                end
                if (pick < 38) begin
                    queue_req(rcbp_pkg::OP_ALLOC, ix);
                end else if (pick < 62) begin
                    queue_req(rcbp_pkg::OP_REF, ix);
                end else if (pick < 94) begin
                    queue_req(rcbp_pkg::OP_UNREF, ix);
                end else begin
                    queue_req(3'($urandom_range(0, OP_BAD_HI)), ix);
                end
            end
            made += len + 1;
            if ($urandom_range(0, 3) != 0) begin
                queue_req(rcbp_pkg::OP_DEINIT, 6'($urandom_range(0, 63)));
                made++;
            end
            if ($urandom_range(0, 4) == 0) begin
                wait_quiet(1'b0);
            end
        end
    endtask

    initial begin : stim
        int m;
        int k;
        send_gap_pct = 23;
        recv_stall_pct = 85;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // pool not yet set up
        queue_req(rcbp_pkg::OP_ALLOC, 6'd0);
        queue_req(rcbp_pkg::OP_REF, 6'd3);
        queue_req(rcbp_pkg::OP_UNREF, 6'd3);
        queue_req(rcbp_pkg::OP_DEINIT, 6'd0);
        queue_req(OP_BAD_HI, 6'h3F);
        queue_req(OP_BAD_LO, 6'd5);
        // default registers, double init, double release, full stack
        queue_req(rcbp_pkg::OP_INIT, 6'd0);
        queue_req(rcbp_pkg::OP_INIT, 6'd0);
        queue_req(rcbp_pkg::OP_ALLOC, 6'd0);
        queue_req(rcbp_pkg::OP_ALLOC, 6'd0);
        queue_req(rcbp_pkg::OP_UNREF, 6'd0);
        queue_req(rcbp_pkg::OP_UNREF, 6'd0);
        queue_req(rcbp_pkg::OP_REF, 6'd63);
        queue_req(rcbp_pkg::OP_UNREF, 6'd63);
        queue_req(rcbp_pkg::OP_UNREF, 6'd1);
        queue_req(rcbp_pkg::OP_DEINIT, 6'd0);
        // rejected init parameters
        load_setting(32'd0, 16'd0, 13'd1, 7'd64);
        queue_req(rcbp_pkg::OP_INIT, 6'd0);
        load_setting(32'hFFFF_FFF0, 16'hFFFF, 13'd4096, 7'd0);
        queue_req(rcbp_pkg::OP_INIT, 6'd0);
        load_setting(32'hFFFF_FFF0, 16'hFFFF, 13'd4096, 7'd127);
        queue_req(rcbp_pkg::OP_INIT, 6'd0);
        // two slots: address wrap, empty pool, index out of range
        load_setting(32'hFFFF_FFF0, 16'hFFFF, 13'd4096, 7'd2);
        queue_req(rcbp_pkg::OP_INIT, 6'd0);
        queue_req(rcbp_pkg::OP_ALLOC, 6'd0);
        queue_req(rcbp_pkg::OP_ALLOC, 6'd0);
        queue_req(rcbp_pkg::OP_ALLOC, 6'd0);
        queue_req(rcbp_pkg::OP_REF, 6'd2);
        queue_req(rcbp_pkg::OP_DEINIT, 6'd0);

        for (m = 0; m < 3; m++) begin
            case (m)
                0: begin
                    send_gap_pct = 23;
                    recv_stall_pct = 85;
                end
                1: begin
                    send_gap_pct = 85;
                    recv_stall_pct = 23;
                end
                default: begin
                    send_gap_pct = 0;
                    recv_stall_pct = 0;
                end
            endcase
            for (k = 0; k < 4; k++) begin
                pick_setting(m * 4 + k);
                queue_req(rcbp_pkg::OP_DEINIT, 6'($urandom_range(0, 63)));
                fill_sessions(80);
            end
        end

        wait_quiet(1'b1);
        if (mismatches == 0 && due_results.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin : watchdog
        #8_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
